FILE: sv/dmtpq_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the earliest-time-first dedup queue
// no dependencies; imported by the cell and the top level

package dmtpq_pkg;

  localparam int DMTPQ_CAPACITY = 16;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_POP = 1'b1;

  localparam logic [1:0] ST_CHANGED = 2'd0;
  localparam logic [1:0] ST_SAME    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [31:0] topic_key;
    logic [47:0] due_time;
  } dmtpq_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        top_valid;
    logic [31:0] top_key;
    logic [47:0] top_time;
    logic [4:0]  entry_count;
  } dmtpq_rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [47:0] due;
  } dmtpq_entry_t;

  // where a cell takes its next entry from
  typedef enum logic [1:0] {
    MV_HOLD,
    MV_LEFT,
    MV_RIGHT,
    MV_NEW
  } dmtpq_move_t;

  typedef struct packed {
    logic        cmp_en;
    dmtpq_move_t move;
  } dmtpq_ctrl_t;

  typedef struct packed {
    logic match;   // holds the same key
    logic ahead;   // served before the incoming entry
    logic lower;   // incoming time is strictly earlier than ours
  } dmtpq_flags_t;

endpackage

FILE: sv/dmtpq_cell.sv
`timescale 1ns / 1ps
// one slot of the sorted entry chain: compares against the request and
// shifts to or from its neighbours; uses dmtpq_pkg

module dmtpq_cell
  import dmtpq_pkg::*;
(
  input  logic         clk,
  input  dmtpq_ctrl_t  ctrl,
  input  logic         valid,
  input  dmtpq_entry_t incoming,
  input  dmtpq_entry_t left,
  input  dmtpq_entry_t right,
  output dmtpq_entry_t entry,
  output dmtpq_entry_t entry_next,
  output dmtpq_flags_t flags
);

  dmtpq_flags_t flags_next;

  always_comb begin
    flags_next.match = valid && (entry.key == incoming.key);
    flags_next.lower = incoming.due < entry.due;
    flags_next.ahead = valid && ((entry.due < incoming.due) ||
                       ((entry.due == incoming.due) && (entry.key < incoming.key)));
  end

  always_comb begin
    case (ctrl.move)
      MV_LEFT:  entry_next = left;
      MV_RIGHT: entry_next = right;
      MV_NEW:   entry_next = incoming;
      default:  entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (ctrl.cmp_en) begin
      flags <= flags_next;
    end
  end

endmodule

FILE: sv/dedup_min_time_priority_queue_core.sv
`timescale 1ns / 1ps
// earliest-time-first queue of unique keys held as a sorted chain of cells
// a request is compared in S_CMP, then S_APPLY shifts the chain and registers the result
// no new request is taken until S_APPLY finishes; it waits while a held result is stalled
// the result register is separate, so a request is taken while a result waits
// synchronous reset empties the queue; entry contents are not cleared
// uses dmtpq_pkg and dmtpq_cell

module dedup_min_time_priority_queue_core
  import dmtpq_pkg::*;
#(
  parameter int CAPACITY = DMTPQ_CAPACITY
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  dmtpq_req_t req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output dmtpq_rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t        state;
  dmtpq_req_t    cur;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  dmtpq_entry_t  ent      [CAPACITY];
  dmtpq_entry_t  ent_nxt  [CAPACITY];
  dmtpq_flags_t  flg      [CAPACITY];
  dmtpq_ctrl_t   ctl      [CAPACITY];
  dmtpq_entry_t  incoming;

  logic          found;
  logic          lower_any;
  logic [IW-1:0] f_idx;
  logic          pop_do;
  logic          ins_do;
  logic          low_do;
  logic [1:0]    status;
  logic          finish;

  assign incoming  = {cur.topic_key, cur.due_time};
  assign req_stall = (state != S_IDLE);
  assign finish    = (state == S_APPLY) && (!rsp_valid || !rsp_stall);

  // position of the matching key, at most one cell matches
  always_comb begin
    found     = 1'b0;
    lower_any = 1'b0;
    f_idx     = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (flg[i].match) begin
        found     = 1'b1;
        lower_any = lower_any | flg[i].lower;
        f_idx     = f_idx | IW'(i);
      end
    end
  end

  always_comb begin
    pop_do = 1'b0;
    ins_do = 1'b0;
    low_do = 1'b0;
    count_next = count;
    if (cur.opcode == OP_POP) begin
      if (count == '0) begin
        status = ST_EMPTY;
      end else begin
        status     = ST_CHANGED;
        pop_do     = 1'b1;
        count_next = count - CW'(1);
      end
    end else if (found) begin
      if (lower_any) begin
        status = ST_CHANGED;
        low_do = 1'b1;
      end else begin
        status = ST_SAME;
      end
    end else if (count == CW'(CAPACITY)) begin
      status = ST_FULL;
    end else begin
      status     = ST_CHANGED;
      ins_do     = 1'b1;
      count_next = count + CW'(1);
    end
  end

  // per-cell move: pop shifts towards the head, add opens a gap at the
  // insertion point and closes the old slot of a lowered key
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      logic at_p;
      logic past_p;
      logic in_span;
      at_p    = !flg[i].ahead && ((i == 0) || flg[(i == 0) ? 0 : i - 1].ahead);
      past_p  = (i != 0) && !flg[(i == 0) ? 0 : i - 1].ahead;
      in_span = ins_do || (IW'(i) <= f_idx);
      ctl[i].cmp_en = (state == S_CMP);
      ctl[i].move   = MV_HOLD;
      if (finish) begin
        if (pop_do) begin
          ctl[i].move = MV_RIGHT;
        end else if (ins_do || low_do) begin
          if (at_p) begin
            ctl[i].move = MV_NEW;
          end else if (past_p && in_span) begin
            ctl[i].move = MV_LEFT;
          end
        end
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    dmtpq_entry_t left;
    dmtpq_entry_t right;
    if (g == 0) begin : g_head
      assign left = '0;
    end else begin : g_mid_l
      assign left = ent[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid_r
      assign right = ent[g+1];
    end

    dmtpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctl[g]),
      .valid      (CW'(g) < count),
      .incoming   (incoming),
      .left       (left),
      .right      (right),
      .entry      (ent[g]),
      .entry_next (ent_nxt[g]),
      .flags      (flg[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (finish) begin
            count           <= count_next;
            rsp.status      <= status;
            rsp.entry_count <= 5'(count_next);
            if (count_next != '0) begin
              rsp.top_valid <= 1'b1;
              rsp.top_key   <= ent_nxt[0].key;
              rsp.top_time  <= ent_nxt[0].due;
            end else begin
              rsp.top_valid <= 1'b0;
              rsp.top_key   <= '0;
              rsp.top_time  <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/dedup_min_time_priority_queue_core_checker.sv
`timescale 1ns / 1ps
// watches both channels of the dedup queue, predicts each result and compares it
// depends on dmtpq_pkg; instantiated beside the block by the test top

module dedup_min_time_priority_queue_core_checker
  import dmtpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_stall,
  input  dmtpq_req_t req,
  input  logic       rsp_valid,
  input  logic       rsp_stall,
  input  dmtpq_rsp_t rsp,
  output int         errors,
  output int         pending
);

  localparam int CAP = DMTPQ_CAPACITY;

  logic [31:0] held_key [CAP];
  logic [47:0] held_due [CAP];
  int          held_count = 0;
  int          fail_count = 0;
  dmtpq_rsp_t  expected_rsp_q[$];
  int          waiting = 0;

  assign errors  = fail_count;
  assign pending = waiting;

  function automatic bit served_first(logic [47:0] ta, logic [31:0] ka,
                                      logic [47:0] tb, logic [31:0] kb);
    if (ta != tb) return ta < tb;
    return ka < kb;
  endfunction

  function automatic int earliest_slot();
    int best = 0;
    for (int i = 1; i < held_count; i++)
      if (served_first(held_due[i], held_key[i], held_due[best], held_key[best]))
        best = i;
    return best;
  endfunction

  // applies one operation to the shadow store and returns the result it should give
  task automatic predict_queue_op(input dmtpq_req_t r, output dmtpq_rsp_t e);
    int hit;
    int s;
    hit = -1;
    e   = '0;
    if (r.opcode == OP_ADD) begin
      for (int i = 0; i < held_count; i++)
        if (hit < 0 && held_key[i] == r.topic_key) hit = i;
      if (hit >= 0) begin
        if (r.due_time < held_due[hit]) begin
          held_due[hit] = r.due_time;
          e.status = ST_CHANGED;
        end else begin
          e.status = ST_SAME;
        end
      end else if (held_count >= CAP) begin
        e.status = ST_FULL;
      end else begin
        held_key[held_count] = r.topic_key;
        held_due[held_count] = r.due_time;
        held_count++;
        e.status = ST_CHANGED;
      end
    end else if (held_count == 0) begin
      e.status = ST_EMPTY;
    end else begin
      // last slot moves into the hole left by the popped entry
      s = earliest_slot();
      held_key[s] = held_key[held_count - 1];
      held_due[s] = held_due[held_count - 1];
      held_count--;
      e.status = ST_CHANGED;
    end
    if (held_count > 0) begin
      s = earliest_slot();
      e.top_valid = 1'b1;
      e.top_key   = held_key[s];
      e.top_time  = held_due[s];
    end
    e.entry_count = 5'(held_count);
  endtask

  function automatic void compare_field(string field, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    dmtpq_rsp_t want;
    if (rst) begin
      held_count = 0;
      expected_rsp_q.delete();
      waiting = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result transfer with no result expected");
          fail_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          compare_field("status", 48'(want.status), 48'(rsp.status));
          compare_field("top_valid", 48'(want.top_valid), 48'(rsp.top_valid));
          compare_field("top_key", 48'(want.top_key), 48'(rsp.top_key));
          compare_field("top_time", want.top_time, rsp.top_time);
          compare_field("entry_count", 48'(want.entry_count), 48'(rsp.entry_count));
        end
      end
      if (req_valid && !req_stall) begin
        predict_queue_op(req, want);
        expected_rsp_q.push_back(want);
      end
      waiting = expected_rsp_q.size();
    end
  end

endmodule

FILE: tb/dedup_min_time_priority_queue_core_test.sv
`timescale 1ns / 1ps
// stimulus and verdict for the dedup earliest-time-first queue
// depends on dmtpq_pkg, the core and dedup_min_time_priority_queue_core_checker

module dedup_min_time_priority_queue_core_test;
  import dmtpq_pkg::*;

  localparam int RANDOM_OPS = 1025;
  localparam int KEY_POOL   = 24;
  localparam int HOLD_OFF   = 200;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  dmtpq_req_t req = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  dmtpq_rsp_t rsp;
  int         fail_count;
  int         pending;

  logic calm = 1'b0;       // no idling on either side
  logic hold_off_go = 1'b0;

  logic [31:0] key_pool [KEY_POOL];

  dedup_min_time_priority_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  dedup_min_time_priority_queue_core_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (fail_count),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("dedup_min_time_priority_queue_core regression: fail");
    $finish;
  end

  // result side: random stalls, one long hold-off while requests keep coming
  initial begin : result_side
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (hold_off_go && !hold_done) begin
        rsp_stall <= 1'b1;
        hold_left = HOLD_OFF - 1;
        hold_done = 1;
      end else if (calm) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 29);
      end
    end
  end

  function automatic dmtpq_req_t op_of(logic opcode, logic [31:0] key, logic [47:0] due);
    dmtpq_req_t r;
    r.opcode    = opcode;
    r.topic_key = key;
    r.due_time  = due;
    return r;
  endfunction

  function automatic logic [47:0] wide_random();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // keys mostly from a small pool so that repeats and lowering happen often
  function automatic dmtpq_req_t random_op(int add_pct);
    dmtpq_req_t r;
    int pick;
    r.opcode = ($urandom_range(99) < add_pct) ? OP_ADD : OP_POP;
    pick = $urandom_range(9);
    if (pick < 7)      r.topic_key = key_pool[$urandom_range(KEY_POOL - 1)];
    else if (pick < 9) r.topic_key = 32'($urandom_range(15));
    else               r.topic_key = $urandom;
    pick = $urandom_range(9);
    if (pick < 5)       r.due_time = 48'($urandom_range(63));
    else if (pick < 8)  r.due_time = wide_random();
    else if (pick == 8) r.due_time = TIME_MAX;
    else                r.due_time = '0;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_op(input dmtpq_req_t item);
    while (!calm && $urandom_range(99) < 29) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int add_pct;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pop, ties, unchanged adds, lowering, full store
    send_op(op_of(OP_POP, 32'hFFFF_FFFF, TIME_MAX));
    send_op(op_of(OP_ADD, 32'hFFFF_FFFF, TIME_MAX));
    send_op(op_of(OP_ADD, 32'h0, TIME_MAX));
    send_op(op_of(OP_ADD, 32'hFFFF_FFFF, TIME_MAX));
    send_op(op_of(OP_ADD, 32'd5, 48'd100));
    send_op(op_of(OP_ADD, 32'd5, 48'd200));
    send_op(op_of(OP_ADD, 32'd5, 48'd0));
    send_op(op_of(OP_ADD, 32'hFFFF_FFFF, 48'd0));
    send_op(op_of(OP_ADD, 32'h0, 48'd0));
    send_op(op_of(OP_POP, $urandom, wide_random()));
    for (int i = 0; i < 13; i++)
      send_op(op_of(OP_ADD, 32'h100 + i, 48'($urandom_range(1000, 1))));
    send_op(op_of(OP_ADD, 32'h200, 48'd7));
    send_op(op_of(OP_ADD, 32'h100, 48'd0));
    send_op(op_of(OP_ADD, 32'h101, TIME_MAX));
    send_op(op_of(OP_POP, 32'hFFFF_FFFF, TIME_MAX));

    // random: add mix changes in phases so the store fills and drains
    add_pct = 60;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(3))
          0: add_pct = 30;
          1: add_pct = 55;
          2: add_pct = 75;
          default: add_pct = 92;
        endcase
      end
      if (n == 100) hold_off_go <= 1'b1;
      if (n == 500) calm <= 1'b1;
      if (n == 650) calm <= 1'b0;
      send_op(random_op(add_pct));
    end
    req_valid <= 1'b0;

    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("dedup_min_time_priority_queue_core regression: pass");
    else
      $display("dedup_min_time_priority_queue_core regression: fail");
    $finish;
  end

endmodule
